### hdl/c2d_pkg.sv
// shared types and constants for the 3x3 full-padding convolution block
package c2d_pkg;

    // default geometry
    localparam int IMG_SIZE_DEF  = 3;
    localparam int KER_SIZE_DEF  = 3;
    localparam int PAD_WIDTH_DEF = 2;

    // field widths
    localparam int REQ_W  = 2;
    localparam int POS_W  = 2;
    localparam int VAL_W  = 32;
    localparam int RES_W  = 3;
    localparam int IN_DW  = 40;
    localparam int OUT_DW = 40;

    // request kinds carried in tuser
    typedef enum logic [REQ_W-1:0] {
        REQ_WEIGHT = 2'd0,
        REQ_PIXEL  = 2'd1,
        REQ_START  = 2'd2
    } t_req_e;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RUN  = 3'b010,
        S_WAIT = 3'b100
    } t_state_e;

endpackage

### hdl/conv2d_3x3_full_pad.sv
// top level: full-padding 2d cross-correlation over image and kernel memories
//
// Load transfers write one kernel weight (tuser 0) or one image pixel (tuser 1)
// into on-chip memories; a load whose row or column is out of range, and
// tuser 3, are dropped. A start transfer (tuser 2) produces
// OUT x OUT sums, OUT = IMG_SIZE - KER_SIZE + 2*PAD_WIDTH + 1 (5 by default),
// in row-major order with tlast on the final one. Each sum is computed by one
// shared multiply-accumulate unit that walks all KER_SIZE*KER_SIZE kernel taps
// (taps falling into the padding contribute zero), reading both memories once
// per tap. The next sum is begun only once the previous one has entered the
// output register, so an output stall holds the whole start. No input is
// taken while a start is being processed. Sums keep the
// low 32 bits and wrap. Entries must be written before a start reads them.
module conv2d_3x3_full_pad #(
    parameter int IMG_SIZE  = c2d_pkg::IMG_SIZE_DEF,
    parameter int KER_SIZE  = c2d_pkg::KER_SIZE_DEF,
    parameter int PAD_WIDTH = c2d_pkg::PAD_WIDTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // input stream
    input  logic                       i_s_tvalid,
    output logic                       o_s_tready,
    // tdata: pos_row [1:0], pos_col [3:2], load_value [35:4], zeros [39:36]
    input  logic [c2d_pkg::IN_DW-1:0]  i_s_tdata,
    // tuser: req_type [1:0]
    input  logic [c2d_pkg::REQ_W-1:0]  i_s_tuser,
    // result stream
    output logic                       o_m_tvalid,
    input  logic                       i_m_tready,
    // tdata: res_row [2:0], res_col [5:3], sum_value [37:6], zeros [39:38]
    output logic [c2d_pkg::OUT_DW-1:0] o_m_tdata,
    // tlast: is_last
    output logic                       o_m_tlast
);
    import c2d_pkg::*;

    localparam int OUT_SIZE = IMG_SIZE - KER_SIZE + 2 * PAD_WIDTH + 1;
    localparam bit HAS_OUT  = (OUT_SIZE > 0);
    localparam int OUT_N    = HAS_OUT ? OUT_SIZE : 1;
    localparam int IMG_N    = IMG_SIZE * IMG_SIZE;
    localparam int KER_N    = KER_SIZE * KER_SIZE;
    localparam int IA_W     = (IMG_N > 1) ? $clog2(IMG_N) : 1;
    localparam int KA_W     = (KER_N > 1) ? $clog2(KER_N) : 1;
    localparam int KC_W     = (KER_SIZE > 1) ? $clog2(KER_SIZE) : 1;
    localparam int OC_W     = (OUT_N > 1) ? $clog2(OUT_N) : 1;
    localparam int SW       = $clog2(OUT_N + KER_SIZE + IMG_SIZE + PAD_WIDTH) + 1;

    // memories
    logic [VAL_W-1:0] r_img_mem [IMG_N];
    logic [VAL_W-1:0] r_ker_mem [KER_N];

    t_state_e         r_state, n_state;
    logic [OC_W-1:0]  r_orow, r_ocol;
    logic [KC_W-1:0]  r_kr, r_kc;

    // read pipeline
    logic [VAL_W-1:0] r_img_q, r_ker_q;
    logic             r_s1_vld, r_s1_ok, r_s1_first, r_s1_last;
    logic [VAL_W-1:0] r_prod;
    logic             r_s2_vld, r_s2_first, r_s2_last;
    logic [VAL_W-1:0] r_acc;
    logic             r_done;

    // output register
    logic             r_out_vld, r_out_last;
    logic [RES_W-1:0] r_out_row, r_out_col;
    logic [VAL_W-1:0] r_out_sum;

    // input field split
    logic [POS_W-1:0] in_row, in_col;
    logic [VAL_W-1:0] in_val;
    logic             in_xfer;
    logic             wr_img, wr_ker;
    logic [IA_W-1:0]  wr_img_addr;
    logic [KA_W-1:0]  wr_ker_addr;

    assign in_row  = i_s_tdata[POS_W-1:0];
    assign in_col  = i_s_tdata[2*POS_W-1:POS_W];
    assign in_val  = i_s_tdata[2*POS_W+VAL_W-1:2*POS_W];
    assign o_s_tready = (r_state == S_IDLE);
    assign in_xfer = i_s_tvalid && o_s_tready;

    // load decode with range check
    always_comb begin
        wr_ker = in_xfer && (i_s_tuser == REQ_WEIGHT)
                 && (int'(in_row) < KER_SIZE) && (int'(in_col) < KER_SIZE);
        wr_img = in_xfer && (i_s_tuser == REQ_PIXEL)
                 && (int'(in_row) < IMG_SIZE) && (int'(in_col) < IMG_SIZE);
        wr_ker_addr = KA_W'(int'(in_row) * KER_SIZE + int'(in_col));
        wr_img_addr = IA_W'(int'(in_row) * IMG_SIZE + int'(in_col));
    end

    // tap address generation
    logic [SW-1:0]   rsum, csum;
    logic            tap_ok, tap_first, tap_last, pt_last, issue;
    logic [IA_W-1:0] rd_img_addr;
    logic [KA_W-1:0] rd_ker_addr;

    always_comb begin
        rsum   = SW'(r_orow) + SW'(r_kr);
        csum   = SW'(r_ocol) + SW'(r_kc);
        tap_ok = (rsum >= SW'(PAD_WIDTH)) && (rsum < SW'(PAD_WIDTH + IMG_SIZE))
                 && (csum >= SW'(PAD_WIDTH)) && (csum < SW'(PAD_WIDTH + IMG_SIZE));
        rd_img_addr = tap_ok
            ? IA_W'((int'(rsum) - PAD_WIDTH) * IMG_SIZE + (int'(csum) - PAD_WIDTH))
            : '0;
        rd_ker_addr = KA_W'(int'(r_kr) * KER_SIZE + int'(r_kc));
        tap_first = (r_kr == '0) && (r_kc == '0);
        tap_last  = (r_kr == KC_W'(KER_SIZE - 1)) && (r_kc == KC_W'(KER_SIZE - 1));
        pt_last   = (r_orow == OC_W'(OUT_N - 1)) && (r_ocol == OC_W'(OUT_N - 1));
        issue     = (r_state == S_RUN);
    end

    // memory write and registered read
    always_ff @(posedge i_clk) begin
        if (wr_img) begin
            r_img_mem[wr_img_addr] <= in_val;
        end
        if (wr_ker) begin
            r_ker_mem[wr_ker_addr] <= in_val;
        end
        r_img_q <= r_img_mem[rd_img_addr];
        r_ker_q <= r_ker_mem[rd_ker_addr];
    end

    logic out_free, emit;
    assign out_free = !r_out_vld || i_m_tready;
    assign emit     = (r_state == S_WAIT) && r_done && out_free;

    // sequencer next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_xfer && (i_s_tuser == REQ_START) && HAS_OUT) begin
                    n_state = S_RUN;
                end
            end
            S_RUN: begin
                if (tap_last) begin
                    n_state = S_WAIT;
                end
            end
            S_WAIT: begin
                if (emit) begin
                    n_state = pt_last ? S_IDLE : S_RUN;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_orow   <= '0;
            r_ocol   <= '0;
            r_kr     <= '0;
            r_kc     <= '0;
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_done   <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_s1_vld <= issue;
            r_s2_vld <= r_s1_vld;
            // tap counters
            if (issue) begin
                if (r_kc == KC_W'(KER_SIZE - 1)) begin
                    r_kc <= '0;
                    r_kr <= (r_kr == KC_W'(KER_SIZE - 1)) ? '0 : r_kr + 1'b1;
                end else begin
                    r_kc <= r_kc + 1'b1;
                end
            end
            // point counters
            if (emit) begin
                if (r_ocol == OC_W'(OUT_N - 1)) begin
                    r_ocol <= '0;
                    r_orow <= (r_orow == OC_W'(OUT_N - 1)) ? '0 : r_orow + 1'b1;
                end else begin
                    r_ocol <= r_ocol + 1'b1;
                end
            end
            // sum finished flag
            if (r_s2_vld && r_s2_last) begin
                r_done <= 1'b1;
            end else if (emit) begin
                r_done <= 1'b0;
            end
            // output valid
            if (emit) begin
                r_out_vld <= 1'b1;
            end else if (i_m_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // multiply and accumulate datapath
    always_ff @(posedge i_clk) begin
        r_s1_ok    <= tap_ok;
        r_s1_first <= tap_first;
        r_s1_last  <= tap_last;
        r_prod     <= r_s1_ok ? VAL_W'(r_img_q * r_ker_q) : '0;
        r_s2_first <= r_s1_first;
        r_s2_last  <= r_s1_last;
        if (r_s2_vld) begin
            r_acc <= r_s2_first ? r_prod : r_acc + r_prod;
        end
        if (emit) begin
            r_out_row  <= RES_W'(r_orow);
            r_out_col  <= RES_W'(r_ocol);
            r_out_sum  <= r_acc;
            r_out_last <= pt_last;
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tlast  = r_out_last;
    assign o_m_tdata  = {{(OUT_DW - 2 * RES_W - VAL_W){1'b0}}, r_out_sum, r_out_col, r_out_row};

    // finished sum only while waiting to hand it over
    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (r_state == S_WAIT))
        else $error("sum flagged done outside wait state");

    // no tap in flight while inputs are taken
    a_pipe_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_vld || r_s2_vld) |-> (r_state != S_IDLE))
        else $error("tap pipeline active while idle");

    // a new sum never starts on top of an unconsumed one
    a_first_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s2_vld && r_s2_first) |-> !r_done)
        else $error("new sum started before previous one was emitted");

    // an emitted sum shows up on the result port
    a_emit_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit |=> o_m_tvalid)
        else $error("emitted sum not presented");

endmodule

### tb/tb_conv2d_3x3_full_pad.sv
`timescale 1ns / 1ps
// self-checking testbench for the 3x3 full-padding convolution block
module tb_conv2d_3x3_full_pad;
    import c2d_pkg::*;

    localparam int IMG          = IMG_SIZE_DEF;
    localparam int KER          = KER_SIZE_DEF;
    localparam int PAD          = PAD_WIDTH_DEF;
    localparam int OUT          = IMG - KER + 2 * PAD + 1;
    localparam int IDLE_PCT     = 6;
    localparam int RANDOM_ITEMS = 120;
    localparam int DRAIN_CYCLES = 50;
    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
    localparam logic [VAL_W-1:0] VAL_MIN    = 32'h8000_0000;
    localparam logic [VAL_W-1:0] VAL_MAX    = 32'h7fff_ffff;
    localparam logic [VAL_W-1:0] VAL_NEG1   = 32'hffff_ffff;

    // one expected output sum
    typedef struct packed {
        logic [RES_W-1:0] row;
        logic [RES_W-1:0] col;
        logic [VAL_W-1:0] sum;
        logic             last;
    } t_sum;

    // mirrors both stores and queues the sums each start transfer should produce
    class conv_scoreboard;
        logic signed [VAL_W-1:0] pixels [IMG*IMG];
        logic signed [VAL_W-1:0] weights[KER*KER];
        t_sum pending[$];
        int   mismatches = 0;

        function void flag(string what);
            mismatches++;
            if (mismatches <= 10) $display("%s", what);
        endfunction

        function void note_input(logic [REQ_W-1:0] kind, logic [POS_W-1:0] row,
                                 logic [POS_W-1:0] col, logic [VAL_W-1:0] val);
            longint acc;
            int     ir;
            int     ic;
            t_sum   s;
            if (kind == REQ_WEIGHT) begin
                if (row < KER && col < KER) weights[row*KER+col] = val;
            end else if (kind == REQ_PIXEL) begin
                if (row < IMG && col < IMG) pixels[row*IMG+col] = val;
            end else if (kind == REQ_START) begin
                for (int r = 0; r < OUT; r++) begin
                    for (int c = 0; c < OUT; c++) begin
                        acc = 0;
                        // taps landing in the zero border add nothing
                        for (int kr = 0; kr < KER; kr++) begin
                            for (int kc = 0; kc < KER; kc++) begin
                                ir = r + kr - PAD;
                                ic = c + kc - PAD;
                                if (ir >= 0 && ir < IMG && ic >= 0 && ic < IMG)
                                    acc += longint'(pixels[ir*IMG+ic]) *
                                           longint'(weights[kr*KER+kc]);
                            end
                        end
                        s.row  = RES_W'(r);
                        s.col  = RES_W'(c);
                        s.sum  = acc[VAL_W-1:0];
                        s.last = (r == OUT - 1 && c == OUT - 1);
                        pending.push_back(s);
                    end
                end
            end
        endfunction

        function void check_sum(logic [OUT_DW-1:0] data, logic last);
            t_sum want;
            t_sum got;
            got.row  = data[RES_W-1:0];
            got.col  = data[2*RES_W-1:RES_W];
            got.sum  = data[2*RES_W+VAL_W-1:2*RES_W];
            got.last = last;
            if (pending.size() == 0) begin
                flag($sformatf("unexpected sum row %0d col %0d value %0d last %0b",
                               got.row, got.col, $signed(got.sum), got.last));
                return;
            end
            want = pending.pop_front();
            if (got.row !== want.row || got.col !== want.col ||
                got.sum !== want.sum || got.last !== want.last)
                flag({$sformatf("sum mismatch: expected row %0d col %0d value %0d last %0b",
                                want.row, want.col, $signed(want.sum), want.last),
                      $sformatf(", got row %0d col %0d value %0d last %0b",
                                got.row, got.col, $signed(got.sum), got.last)});
        endfunction
    endclass

    logic              clk;
    logic              rst_n    = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [IN_DW-1:0]  s_tdata  = '0;
    logic [REQ_W-1:0]  s_tuser  = REQ_WEIGHT;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [OUT_DW-1:0] m_tdata;
    logic              m_tlast;
    bit                calm     = 1'b0;

    conv_scoreboard board = new();

    conv2d_3x3_full_pad dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tlast  (m_tlast)
    );

    // clock
    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // extreme values mixed with small and fully random words
    function automatic logic [VAL_W-1:0] rand_word();
        case ($urandom_range(9))
            0: return VAL_MIN;
            1: return VAL_MAX;
            2: return VAL_NEG1;
            3: return '0;
            4: return 32'd1;
            5, 6: return 32'($urandom_range(200)) - 32'd100;
            default: return $urandom;
        endcase
    endfunction

    // one input transfer, with occasional idle cycles ahead of it
    task automatic send(input logic [REQ_W-1:0] kind, input logic [POS_W-1:0] row,
                        input logic [POS_W-1:0] col, input logic [VAL_W-1:0] val);
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(IN_DW - 2 * POS_W - VAL_W){1'b0}}, val, col, row};
        s_tuser  <= kind;
        do @(posedge clk); while (!s_tready);
        board.note_input(kind, row, col, val);
    endtask

    // stimulus
    initial begin
        logic [VAL_W-1:0] w_dir[KER*KER];
        logic [VAL_W-1:0] p_dir[IMG*IMG];
        logic [REQ_W-1:0] kind;
        int counted;
        int pick;

        w_dir = '{VAL_MIN, VAL_MAX, VAL_NEG1, 32'd1, 32'd0, VAL_MIN, VAL_MAX,
                  VAL_MIN, VAL_NEG1};
        p_dir = '{VAL_MIN, VAL_MIN, VAL_MAX, VAL_NEG1, 32'd0, 32'd1, VAL_MAX,
                  VAL_MIN, VAL_MIN};
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // fill both stores with extremes so the sums overflow
        for (int i = 0; i < KER * KER; i++)
            send(REQ_WEIGHT, POS_W'(i / KER), POS_W'(i % KER), w_dir[i]);
        for (int i = 0; i < IMG * IMG; i++)
            send(REQ_PIXEL, POS_W'(i / IMG), POS_W'(i % IMG), p_dir[i]);
        // unknown request and out-of-range loads must leave the stores alone
        send(REQ_UNUSED, 2'd1, 2'd1, 32'h5a5a_5a5a);
        send(REQ_WEIGHT, 2'd3, 2'd0, 32'h1234_5678);
        send(REQ_PIXEL, 2'd0, 2'd3, 32'h7654_3210);
        send(REQ_PIXEL, 2'd3, 2'd3, VAL_NEG1);
        send(REQ_START, 2'd0, 2'd0, '0);

        // random reloads with starts in between, a little noise, one calm stretch
        counted = 0;
        while (counted < RANDOM_ITEMS) begin
            calm = (counted >= 60 && counted < 100);
            pick = $urandom_range(99);
            if (pick < 10) begin
                send(REQ_START, POS_W'($urandom_range(3)), POS_W'($urandom_range(3)),
                     $urandom);
                counted++;
            end else if (pick < 90) begin
                kind = (pick < 50) ? REQ_WEIGHT : REQ_PIXEL;
                send(kind, POS_W'($urandom_range(2)), POS_W'($urandom_range(2)),
                     rand_word());
                counted++;
            end else if (pick < 94) begin
                send(REQ_UNUSED, POS_W'($urandom_range(3)), POS_W'($urandom_range(3)),
                     rand_word());
            end else begin
                kind = $urandom_range(1) ? REQ_WEIGHT : REQ_PIXEL;
                if ($urandom_range(1))
                    send(kind, 2'd3, POS_W'($urandom_range(3)), rand_word());
                else
                    send(kind, POS_W'($urandom_range(3)), 2'd3, rand_word());
            end
        end
        calm = 1'b0;
        send(REQ_START, 2'd2, 2'd1, $urandom);
        s_tvalid <= 1'b0;

        // drain, then allow time for any stray output
        while (board.pending.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (board.mismatches == 0 && board.pending.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // result side: check each transfer, then pick next cycle's tready
    initial begin
        forever begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready) board.check_sum(m_tdata, m_tlast);
            m_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // watchdog
    initial begin
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
